### design/ecpb_pkg.sv
// ---------------------------------------------------------------------------
// ecpb_pkg: shared constants and types for the color palette builder
// Table geometry, field widths and the controller/datapath handshake structs.
// ---------------------------------------------------------------------------
package ecpb_pkg;

    localparam int TABLE_DEPTH = 256;
    localparam int IDX_W       = $clog2(TABLE_DEPTH);
    localparam int CNT_W       = $clog2(TABLE_DEPTH + 1);

    localparam int PIXEL_W     = 32;
    localparam int COLOR_IDX_W = 8;
    localparam int COLOR_CNT_W = 9;

    localparam int PADDR_W     = 3;
    localparam int PDATA_W     = 32;

    // register indexes, selected by paddr[2]
    localparam logic REG_PIXEL_MODE = 1'b0;
    localparam logic REG_ENDIAN     = 1'b1;

    // pixel mode and byte order codes
    localparam logic MODE_16BIT = 1'b0;
    localparam logic MODE_32BIT = 1'b1;
    localparam logic ORDER_LSB_FIRST = 1'b0;
    localparam logic ORDER_MSB_FIRST = 1'b1;

    typedef struct packed {
        logic load;     // latch a new pixel, clear table on start of image
        logic scan;     // issue table reads and compare
        logic commit;   // append on miss and load the result register
    } ecpb_cmd_t;

    typedef struct packed {
        logic done;     // search settled: hit, miss or overflow
    } ecpb_sts_t;

endpackage

### design/ecpb_pix_if.sv
// ---------------------------------------------------------------------------
// ecpb_pix_if: pixel input channel
// Valid/ready channel carrying one framebuffer pixel per beat.
// ---------------------------------------------------------------------------
interface ecpb_pix_if;

    logic                         valid;
    logic                         ready;
    logic                         start_of_image;
    logic [ecpb_pkg::PIXEL_W-1:0] pixel_bytes;

    modport source (
        output valid,
        output start_of_image,
        output pixel_bytes,
        input  ready
    );

    modport sink (
        input  valid,
        input  start_of_image,
        input  pixel_bytes,
        output ready
    );

endinterface

### design/ecpb_res_if.sv
// ---------------------------------------------------------------------------
// ecpb_res_if: palette result channel
// Valid/ready channel carrying one lookup result per beat.
// ---------------------------------------------------------------------------
interface ecpb_res_if;

    logic                             valid;
    logic                             ready;
    logic [ecpb_pkg::COLOR_IDX_W-1:0] color_index;
    logic                             new_color;
    logic [ecpb_pkg::COLOR_CNT_W-1:0] color_count;
    logic                             overflow;

    modport source (
        output valid,
        output color_index,
        output new_color,
        output color_count,
        output overflow,
        input  ready
    );

    modport sink (
        input  valid,
        input  color_index,
        input  new_color,
        input  color_count,
        input  overflow,
        output ready
    );

endinterface

### design/ecpb_ctrl.sv
// ---------------------------------------------------------------------------
// ecpb_ctrl: sequencing state machine
// Steps each pixel through load, table scan and commit; owns result valid.
// ---------------------------------------------------------------------------
module ecpb_ctrl (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  in_valid,
    output logic                  in_ready,
    output logic                  out_valid,
    input  logic                  out_ready,
    output ecpb_pkg::ecpb_cmd_t   cmd,
    input  ecpb_pkg::ecpb_sts_t   sts
);

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_DONE
    } state_t;

    state_t state_reg;
    state_t state_next;
    logic   out_valid_reg;
    logic   out_valid_next;
    logic   out_free;

    assign out_free  = !out_valid_reg || out_ready;
    assign in_ready  = (state_reg == ST_IDLE);
    assign out_valid = out_valid_reg;

    always_comb
    begin
        state_next     = state_reg;
        out_valid_next = out_valid_reg && !out_ready;
        cmd            = '0;
        case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.load   = 1'b1;
                    state_next = ST_SCAN;
                end
            end
            ST_SCAN:
            begin
                cmd.scan = 1'b1;
                if (sts.done)
                begin
                    state_next = ST_DONE;
                end
            end
            ST_DONE:
            begin
                // hold until the result register can take the beat
                if (out_free)
                begin
                    cmd.commit     = 1'b1;
                    out_valid_next = 1'b1;
                    state_next     = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

endmodule

### design/ecpb_dp.sv
// ---------------------------------------------------------------------------
// ecpb_dp: palette datapath
// Pixel assembly, color table memory, sequential compare and result register.
// ---------------------------------------------------------------------------
module ecpb_dp (
    input  logic                                clk,
    input  logic                                rst_n,
    input  ecpb_pkg::ecpb_cmd_t                 cmd,
    output ecpb_pkg::ecpb_sts_t                 sts,
    input  logic                                pixel_mode,
    input  logic                                pix_endian,
    input  logic                                start_of_image,
    input  logic [ecpb_pkg::PIXEL_W-1:0]        pixel_bytes,
    output logic [ecpb_pkg::COLOR_IDX_W-1:0]    color_index,
    output logic                                new_color,
    output logic [ecpb_pkg::COLOR_CNT_W-1:0]    color_count,
    output logic                                overflow
);

    localparam int IDX_W = ecpb_pkg::IDX_W;
    localparam int CNT_W = ecpb_pkg::CNT_W;
    localparam int PIX_W = ecpb_pkg::PIXEL_W;
    localparam logic [CNT_W-1:0] DEPTH_CNT = CNT_W'(ecpb_pkg::TABLE_DEPTH);

    function automatic logic [PIX_W-1:0] assemble(
        input logic             mode,
        input logic             order,
        input logic [PIX_W-1:0] raw
    );
        logic [PIX_W-1:0] val;
        begin
            if (mode == ecpb_pkg::MODE_16BIT)
            begin
                if (order == ecpb_pkg::ORDER_LSB_FIRST)
                    val = {16'h0000, raw[15:8], raw[7:0]};
                else
                    val = {16'h0000, raw[7:0], raw[15:8]};
            end
            else
            begin
                if (order == ecpb_pkg::ORDER_LSB_FIRST)
                    val = raw;
                else
                    val = {raw[7:0], raw[15:8], raw[23:16], raw[31:24]};
            end
            return val;
        end
    endfunction

    logic [PIX_W-1:0] color_mem [ecpb_pkg::TABLE_DEPTH];

    logic [PIX_W-1:0] pixel_reg;
    logic [PIX_W-1:0] rd_data_reg;
    logic [IDX_W-1:0] rd_idx_reg;
    logic [IDX_W-1:0] hit_idx_reg;
    logic [CNT_W-1:0] count_reg;
    logic [CNT_W-1:0] count_next;
    logic [CNT_W-1:0] scan_reg;
    logic [CNT_W-1:0] scan_next;
    logic             ovf_reg;
    logic             ovf_next;
    logic             hit_reg;
    logic             hit_next;
    logic             rd_vld_reg;
    logic             rd_vld_next;

    logic             hit_now;
    logic             issue;
    logic             append;
    logic [CNT_W-1:0] count_inc;
    logic             ovf_after;

    logic [ecpb_pkg::COLOR_IDX_W-1:0] idx_out_reg;
    logic                             new_out_reg;
    logic [ecpb_pkg::COLOR_CNT_W-1:0] cnt_out_reg;
    logic                             ovf_out_reg;

    assign hit_now   = rd_vld_reg && (rd_data_reg == pixel_reg);
    assign issue     = cmd.scan && !ovf_reg && !hit_now && (scan_reg < count_reg);
    assign sts.done  = ovf_reg || hit_now || (!rd_vld_reg && (scan_reg >= count_reg));
    assign append    = !ovf_reg && !hit_reg;
    assign count_inc = count_reg + CNT_W'(1);
    assign ovf_after = ovf_reg || (append && (count_inc == DEPTH_CNT));

    always_comb
    begin
        count_next  = count_reg;
        ovf_next    = ovf_reg;
        hit_next    = hit_reg;
        scan_next   = scan_reg;
        rd_vld_next = 1'b0;
        if (cmd.load)
        begin
            // drop the table contents on a new image
            if (start_of_image)
            begin
                count_next = '0;
                ovf_next   = 1'b0;
            end
            hit_next  = 1'b0;
            scan_next = '0;
        end
        if (cmd.scan)
        begin
            rd_vld_next = issue;
            if (issue)
                scan_next = scan_reg + CNT_W'(1);
            if (hit_now)
                hit_next = 1'b1;
        end
        if (cmd.commit)
        begin
            if (append)
                count_next = count_inc;
            ovf_next = ovf_after;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg  <= '0;
            ovf_reg    <= 1'b0;
            hit_reg    <= 1'b0;
            scan_reg   <= '0;
            rd_vld_reg <= 1'b0;
        end
        else
        begin
            count_reg  <= count_next;
            ovf_reg    <= ovf_next;
            hit_reg    <= hit_next;
            scan_reg   <= scan_next;
            rd_vld_reg <= rd_vld_next;
        end
    end

    // table memory: one write port, one registered read port
    always_ff @(posedge clk)
    begin
        if (cmd.commit && append)
            color_mem[count_reg[IDX_W-1:0]] <= pixel_reg;
        if (issue)
            rd_data_reg <= color_mem[scan_reg[IDX_W-1:0]];
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
            pixel_reg <= assemble(pixel_mode, pix_endian, pixel_bytes);
        if (issue)
            rd_idx_reg <= scan_reg[IDX_W-1:0];
        if (cmd.scan && hit_now)
            hit_idx_reg <= rd_idx_reg;
        if (cmd.commit)
        begin
            if (ovf_after)
                idx_out_reg <= '0;
            else if (append)
                idx_out_reg <= ecpb_pkg::COLOR_IDX_W'(count_reg[IDX_W-1:0]);
            else
                idx_out_reg <= ecpb_pkg::COLOR_IDX_W'(hit_idx_reg);
            new_out_reg <= append;
            cnt_out_reg <= ecpb_pkg::COLOR_CNT_W'(append ? count_inc : count_reg);
            ovf_out_reg <= ovf_after;
        end
    end

    assign color_index = idx_out_reg;
    assign new_color   = new_out_reg;
    assign color_count = cnt_out_reg;
    assign overflow    = ovf_out_reg;

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= DEPTH_CNT)
        else $error("entry count beyond table depth");

    a_ovf_full: assert property (@(posedge clk) disable iff (!rst_n)
        ovf_reg |-> (count_reg == DEPTH_CNT))
        else $error("overflow set with table not full");

    a_read_written: assert property (@(posedge clk) disable iff (!rst_n)
        rd_vld_reg |-> (CNT_W'(rd_idx_reg) < count_reg))
        else $error("compare against an unwritten entry");

    a_append_step: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.commit && append) |=> (count_reg == $past(count_inc)))
        else $error("append did not advance the entry count");

endmodule

### design/exact_color_palette_builder.sv
// ---------------------------------------------------------------------------
// exact_color_palette_builder: exact-match color palette extraction
// Operation: each input beat is loaded, then the stored colors are scanned
//   until a hit or the last stored color, then the result is committed and
//   offered; an empty table or a set overflow skips the scan.
// Throughput: one pixel at a time; one table read per cycle during the scan,
//   which reads all stored colors on a miss and stops at the entry on a hit.
// Reset: entry count and overflow clear, pixel_mode = 1, pix_endian = 0;
//   the color table itself is not cleared and needs no clearing pass.
// ---------------------------------------------------------------------------
module exact_color_palette_builder (
    input  logic                            clk,
    input  logic                            rst_n,
    ecpb_pix_if.sink                        pix_in,
    ecpb_res_if.source                      res_out,
    input  logic                            psel,
    input  logic                            penable,
    input  logic                            pwrite,
    input  logic [ecpb_pkg::PADDR_W-1:0]    paddr,
    input  logic [ecpb_pkg::PDATA_W-1:0]    pwdata,
    output logic [ecpb_pkg::PDATA_W-1:0]    prdata,
    output logic                            pready
);

    ecpb_pkg::ecpb_cmd_t cmd;
    ecpb_pkg::ecpb_sts_t sts;

    logic pixel_mode_reg;
    logic pix_endian_reg;
    logic cfg_wr;
    logic reg_sel;

    // -----------------------------------------------------------------------
    // Configuration registers. Word address in paddr[2]: register 0 holds
    // the pixel mode, register 1 the byte order. Zero wait states.
    // -----------------------------------------------------------------------
    assign pready  = 1'b1;
    assign reg_sel = paddr[2];
    assign cfg_wr  = psel && penable && pwrite && pready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pixel_mode_reg <= ecpb_pkg::MODE_32BIT;
            pix_endian_reg <= ecpb_pkg::ORDER_LSB_FIRST;
        end
        else if (cfg_wr)
        begin
            case (reg_sel)
                ecpb_pkg::REG_PIXEL_MODE: pixel_mode_reg <= pwdata[0];
                ecpb_pkg::REG_ENDIAN:     pix_endian_reg <= pwdata[0];
                default:                  pixel_mode_reg <= pixel_mode_reg;
            endcase
        end
    end

    always_comb
    begin
        prdata = '0;
        case (reg_sel)
            ecpb_pkg::REG_PIXEL_MODE: prdata[0] = pixel_mode_reg;
            ecpb_pkg::REG_ENDIAN:     prdata[0] = pix_endian_reg;
            default:                  prdata    = '0;
        endcase
    end

    // -----------------------------------------------------------------------
    // Controller: takes one input beat, runs the table scan until the
    // datapath reports a settled search, then commits into the result
    // register once it is free. A waiting result does not stop the next
    // pixel from being taken and searched.
    // -----------------------------------------------------------------------
    ecpb_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (pix_in.valid),
        .in_ready  (pix_in.ready),
        .out_valid (res_out.valid),
        .out_ready (res_out.ready),
        .cmd       (cmd),
        .sts       (sts)
    );

    // -----------------------------------------------------------------------
    // Datapath: assembles the pixel value, streams stored colors out of the
    // table memory one per cycle and compares each against the pixel;
    // appends on a miss and raises sticky overflow when the table fills.
    // -----------------------------------------------------------------------
    ecpb_dp u_dp (
        .clk            (clk),
        .rst_n          (rst_n),
        .cmd            (cmd),
        .sts            (sts),
        .pixel_mode     (pixel_mode_reg),
        .pix_endian     (pix_endian_reg),
        .start_of_image (pix_in.start_of_image),
        .pixel_bytes    (pix_in.pixel_bytes),
        .color_index    (res_out.color_index),
        .new_color      (res_out.new_color),
        .color_count    (res_out.color_count),
        .overflow       (res_out.overflow)
    );

endmodule
